// ----- rtl/tswt_pkg.sv -----
// Package for the task sleep and wait table.
// Holds the item kind and status codes and the sequencer state type; no dependencies.
package tswt_pkg;

    typedef enum logic [1:0] {
        FUNC_SLEEP_TIMED = 2'd0,
        FUNC_SLEEP_ADDR  = 2'd1,
        FUNC_WAKE_ADDR   = 2'd2,
        FUNC_TICK        = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_NO_TASK = 2'd2,
        STATUS_RSVD    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EMIT,
        ST_DONE
    } t_state;

    localparam logic [15:0] SCAN_PERIOD_RESET = 16'd100;

endpackage

// ----- rtl/task_sleep_wait_table_top.sv -----
// Top level of the task sleep and wait table.
// Depends on tswt_pkg; the entry payload lives in an internal synchronous memory.
//
//  channel  | handshake                  | payload
//  input    | i_valid / o_stall          | i_func i_task_id i_task_present i_sleep_ticks
//           |                            | i_wait_address
//  output   | o_valid / i_stall          | o_woke o_woken_task o_status o_last
//  config   | i_cfg_we                   | i_cfg_data (scan_period)
//
// A sleep or a tick without a scan is accepted and its result is registered as it
// is accepted, so such items can follow each other with no gap unless a held result
// is stalled. A scan or an address wake walks the entry memory through its one
// read port: each entry is read, then checked, a woken task passes an emit step,
// and a final step sends the last result. Valid bits live in flops, so reset needs
// no clearing pass. i_stall holds a result in the output register and pauses the
// walk; o_stall is high while an item is in work or a held result is stalled.
module task_sleep_wait_table_top #(
    parameter int ENTRIES   = 16,
    parameter int TICK_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_task_id,
    input  logic        i_task_present,
    input  logic [31:0] i_sleep_ticks,
    input  logic [63:0] i_wait_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_woke,
    output logic [7:0]  o_woken_task,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import tswt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int MW = 1 + 8 + TICK_BITS + 32 + 64;

    // Entry memory: {timed, task, start, duration, address}.
    logic [MW-1:0] mem [ENTRIES];
    logic [MW-1:0] r_rdata;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    t_state                r_state, n_state;
    logic [ENTRIES-1:0]    r_vld, n_vld;
    logic [TICK_BITS-1:0]  r_tick, n_tick;
    logic [15:0]           r_tts, n_tts;
    logic [15:0]           r_period;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_scan, n_scan;
    logic [63:0]           r_addr, n_addr;
    logic                  r_any, n_any;
    logic [7:0]            r_ptask, n_ptask;
    logic                  r_ov, n_ov;
    logic                  r_owoke, n_owoke;
    logic [7:0]            r_otask, n_otask;
    logic [1:0]            r_ostat, n_ostat;
    logic                  r_olast, n_olast;

    // Fields of the entry just read.
    logic                  e_timed;
    logic [7:0]            e_task;
    logic [TICK_BITS-1:0]  e_start;
    logic [31:0]           e_dur;
    logic [63:0]           e_addr;
    logic [TICK_BITS-1:0]  elapsed;
    logic                  hit;
    logic                  out_free;
    logic [IW-1:0]         cur;
    logic                  free_found;
    logic [IW-1:0]         free_idx;
    logic [TICK_BITS-1:0]  tick_inc;
    logic [15:0]           tts_inc;

    assign {e_timed, e_task, e_start, e_dur, e_addr} = r_rdata;
    assign elapsed  = r_tick - e_start;
    assign cur      = r_idx[IW-1:0];
    assign out_free = !r_ov || !i_stall;
    assign tick_inc = r_tick + 1'b1;
    assign tts_inc  = r_tts + 16'd1;

    // A valid entry matches on expiry when scanning, on address otherwise.
    always_comb begin
        if (r_scan) begin
            hit = r_vld[cur] && e_timed && (e_dur != 32'd0)
                  && (64'(elapsed) >= 64'(e_dur));
        end else begin
            hit = r_vld[cur] && !e_timed && (e_addr == r_addr);
        end
    end

    // Lowest free entry.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_vld[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // Sequencer: next state, memory access and result register.
    always_comb begin
        n_state   = r_state;
        n_vld     = r_vld;
        n_tick    = r_tick;
        n_tts     = r_tts;
        n_idx     = r_idx;
        n_scan    = r_scan;
        n_addr    = r_addr;
        n_any     = r_any;
        n_ptask   = r_ptask;
        n_ov      = r_ov && i_stall;
        n_owoke   = r_owoke;
        n_otask   = r_otask;
        n_ostat   = r_ostat;
        n_olast   = r_olast;
        mem_we    = 1'b0;
        mem_waddr = free_idx;
        mem_wdata = '0;
        mem_raddr = cur;
        o_stall   = (r_state != ST_IDLE) || (r_ov && i_stall);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_ov    = 1'b1;
                    n_owoke = 1'b0;
                    n_otask = 8'd0;
                    n_ostat = STATUS_OK;
                    n_olast = 1'b1;
                    unique case (t_func'(i_func))
                        FUNC_SLEEP_TIMED, FUNC_SLEEP_ADDR: begin
                            if (!i_task_present) begin
                                n_ostat = STATUS_NO_TASK;
                            end else if (!free_found) begin
                                n_ostat = STATUS_FULL;
                            end else begin
                                mem_we = 1'b1;
                                n_vld[free_idx] = 1'b1;
                                if (i_func == FUNC_SLEEP_TIMED) begin
                                    mem_wdata = {1'b1, i_task_id, r_tick, i_sleep_ticks,
                                                 64'd0};
                                end else begin
                                    mem_wdata = {1'b0, i_task_id, r_tick, 32'd0,
                                                 i_wait_address};
                                end
                            end
                        end
                        FUNC_WAKE_ADDR: begin
                            n_ov    = 1'b0;
                            n_scan  = 1'b0;
                            n_addr  = i_wait_address;
                            n_idx   = '0;
                            n_any   = 1'b0;
                            n_state = ST_READ;
                        end
                        FUNC_TICK: begin
                            n_tick = tick_inc;
                            if (tts_inc >= r_period) begin
                                n_tts   = 16'd0;
                                n_ov    = 1'b0;
                                n_scan  = 1'b1;
                                n_idx   = '0;
                                n_any   = 1'b0;
                                n_state = ST_READ;
                            end else begin
                                n_tts = tts_inc;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                // The read address was presented this cycle.
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (hit) begin
                    n_state = ST_EMIT;
                end else if (r_idx == CW'(ENTRIES - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_EMIT: begin
                // The woken task is held until it is known whether another follows;
                // the task held before it goes out once the output is free.
                if (!r_any || out_free) begin
                    if (r_any) begin
                        n_ov    = 1'b1;
                        n_owoke = 1'b1;
                        n_otask = r_ptask;
                        n_ostat = STATUS_OK;
                        n_olast = 1'b0;
                    end
                    n_ptask    = e_task;
                    n_any      = 1'b1;
                    n_vld[cur] = 1'b0;
                    if (r_idx == CW'(ENTRIES - 1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            ST_DONE: begin
                // Send the held task marked last, or the empty result.
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_owoke = r_any;
                    n_otask = r_any ? r_ptask : 8'd0;
                    n_ostat = STATUS_OK;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_vld    <= '0;
            r_tick   <= '0;
            r_tts    <= '0;
            r_period <= SCAN_PERIOD_RESET;
            r_ov     <= 1'b0;
            r_idx    <= '0;
            r_scan   <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_tick  <= n_tick;
            r_tts   <= n_tts;
            r_ov    <= n_ov;
            r_idx   <= n_idx;
            r_scan  <= n_scan;
            r_any   <= n_any;
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_ptask <= n_ptask;
        r_owoke <= n_owoke;
        r_otask <= n_otask;
        r_ostat <= n_ostat;
        r_olast <= n_olast;
    end

    assign o_valid      = r_ov;
    assign o_woke       = r_owoke;
    assign o_woken_task = r_otask;
    assign o_status     = r_ostat;
    assign o_last       = r_olast;

    // A woken result is never reported together with an error status.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_woke |-> o_status == STATUS_OK)
        else $error("woken result carries an error status");

    // While a walk is in progress, no new transaction is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> o_stall)
        else $error("input taken during a walk");

    // An emitted wake clears the valid bit of its entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT && out_free |=> !r_vld[$past(cur)])
        else $error("woken entry still valid");

endmodule
